// ----- hw/rtl/irpd_pkg.sv -----
// irpd_pkg: shared types and constants for the pulse-distance ir receiver
// no dependencies; used by irpd_core and ir_pulse_distance_receiver_top
`default_nettype none

package irpd_pkg;

  // fixed field widths
  localparam int TIME_W  = 32;
  localparam int CFG_W   = 16;
  localparam int WORD_W  = 24;
  localparam int BITS_W  = 6;
  localparam int INDEX_W = 3;

  // operation codes
  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_READ = 1'b1;

  // configuration register indexes
  localparam logic [INDEX_W-1:0] REG_LEADER_MIN    = 3'd0;
  localparam logic [INDEX_W-1:0] REG_LEADER_MAX    = 3'd1;
  localparam logic [INDEX_W-1:0] REG_BIT_MIN       = 3'd2;
  localparam logic [INDEX_W-1:0] REG_BIT_MAX       = 3'd3;
  localparam logic [INDEX_W-1:0] REG_ONE_THRESHOLD = 3'd4;

  // configuration reset values
  localparam logic [CFG_W-1:0] LEADER_MIN_RST    = 16'd11000;
  localparam logic [CFG_W-1:0] LEADER_MAX_RST    = 16'd16000;
  localparam logic [CFG_W-1:0] BIT_MIN_RST       = 16'd700;
  localparam logic [CFG_W-1:0] BIT_MAX_RST       = 16'd3000;
  localparam logic [CFG_W-1:0] ONE_THRESHOLD_RST = 16'd1600;

  typedef struct packed {
    logic              op;
    logic [TIME_W-1:0] edge_time;
  } in_t;

  typedef struct packed {
    logic              read_ok;
    logic [WORD_W-1:0] packet;
    logic              receiving;
    logic              frame_done;
  } out_t;

  typedef struct packed {
    logic [CFG_W-1:0] leader_min;
    logic [CFG_W-1:0] leader_max;
    logic [CFG_W-1:0] bit_min;
    logic [CFG_W-1:0] bit_max;
    logic [CFG_W-1:0] one_threshold;
  } cfg_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ir_pulse_distance_receiver_top.sv -----
// Pulse-distance infrared frame receiver. Edge words carry the microsecond
// timestamp of a falling edge; the interval to the previous edge selects leader,
// data bit (one at or above the threshold, LSB first) or abort; outside a frame
// only a leader counts. After PACKET_BITS bits the packet is held until a read
// word takes it. The block accepts one word per clock unless the output stalls
// and returns one result word for each, via the input register and then the
// result register, with the decode state updated in between. Configuration
// writes take effect on the next cycle and are meant for idle periods.
// depends on irpd_pkg and irpd_core
`default_nettype none

module ir_pulse_distance_receiver_top #(
  parameter int PACKET_BITS = 24
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire irpd_pkg::in_t                       in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output irpd_pkg::out_t                           out_data,
  input  wire logic                               wr_en,
  input  wire logic [irpd_pkg::INDEX_W-1:0]       wr_index,
  input  wire logic [irpd_pkg::CFG_W-1:0]         wr_data
);
  import irpd_pkg::*;

  cfg_t cfg;
  in_t  in_q;
  logic in_q_valid;
  logic advance;
  out_t result;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.leader_min    <= LEADER_MIN_RST;
      cfg.leader_max    <= LEADER_MAX_RST;
      cfg.bit_min       <= BIT_MIN_RST;
      cfg.bit_max       <= BIT_MAX_RST;
      cfg.one_threshold <= ONE_THRESHOLD_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_LEADER_MIN:    cfg.leader_min    <= wr_data;
        REG_LEADER_MAX:    cfg.leader_max    <= wr_data;
        REG_BIT_MIN:       cfg.bit_min       <= wr_data;
        REG_BIT_MAX:       cfg.bit_max       <= wr_data;
        REG_ONE_THRESHOLD: cfg.one_threshold <= wr_data;
        default: ;
      endcase
    end
  end

  // pipeline flow control
  assign advance  = in_q_valid && (!out_valid || out_ready);
  assign in_ready = !in_q_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  // decode state and update
  irpd_core #(
    .PACKET_BITS(PACKET_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .take   (advance),
    .item   (in_q),
    .cfg    (cfg),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  // checks
  a_done_leaves_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_done |-> !out_data.receiving)
    else $error("frame_done while still receiving");

  a_read_not_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.read_ok |-> !out_data.frame_done)
    else $error("read result reports a completed frame");

  a_packet_only_on_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.read_ok |-> out_data.packet == '0)
    else $error("packet bits without read_ok");

  a_held_word_kept: assert property (@(posedge clk) disable iff (rst)
    in_q_valid && !advance |=> in_q_valid && $stable(in_q))
    else $error("stalled input word lost or changed");

endmodule

`default_nettype wire

// ----- hw/rtl/irpd_core.sv -----
// irpd_core: frame decode state and the per-word update
// depends on irpd_pkg
`default_nettype none

module irpd_core #(
  parameter int PACKET_BITS = 24
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          take,
  input  wire irpd_pkg::in_t  item,
  input  wire irpd_pkg::cfg_t cfg,
  output irpd_pkg::out_t      result
);
  import irpd_pkg::*;

  logic [TIME_W-1:0] last_edge_time, last_edge_time_next;
  logic              in_frame, in_frame_next;
  logic [BITS_W-1:0] bits_taken, bits_taken_next, bits_inc;
  logic [WORD_W-1:0] shift_word, shift_word_next;
  logic              packet_ready, packet_ready_next;

  logic [TIME_W-1:0] interval;
  logic              leader_hit, bit_hit, bit_val;

  // interval since last edge, wraps modulo 2^32
  assign interval   = item.edge_time - last_edge_time;
  assign leader_hit = (interval >= TIME_W'(cfg.leader_min)) &&
                      (interval <= TIME_W'(cfg.leader_max));
  assign bit_hit    = (interval >= TIME_W'(cfg.bit_min)) &&
                      (interval <= TIME_W'(cfg.bit_max));
  assign bit_val    = interval >= TIME_W'(cfg.one_threshold);
  assign bits_inc   = bits_taken + BITS_W'(1);

  // next state and result for the word in the input register
  always_comb begin
    last_edge_time_next = last_edge_time;
    in_frame_next       = in_frame;
    bits_taken_next     = bits_taken;
    shift_word_next     = shift_word;
    packet_ready_next   = packet_ready;
    result              = '0;
    if (item.op == OP_READ) begin
      if (packet_ready) begin
        result.read_ok    = 1'b1;
        result.packet     = shift_word;
        packet_ready_next = 1'b0;
      end
    end else begin
      last_edge_time_next = item.edge_time;
      if (!in_frame) begin
        if (leader_hit) begin
          in_frame_next   = 1'b1;
          bits_taken_next = '0;
          shift_word_next = '0;
        end
      end else if (bit_hit) begin
        // bit positions past the word are counted only
        if (bits_taken < BITS_W'(WORD_W)) begin
          shift_word_next = shift_word | (WORD_W'(bit_val) << bits_taken[4:0]);
        end
        bits_taken_next = bits_inc;
        if (bits_inc >= BITS_W'(PACKET_BITS)) begin
          packet_ready_next = 1'b1;
          in_frame_next     = 1'b0;
          result.frame_done = 1'b1;
        end
      end else begin
        in_frame_next   = 1'b0;
        bits_taken_next = '0;
        shift_word_next = '0;
      end
    end
    result.receiving = in_frame_next;
  end

  // state registers, updated once per word taken
  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge_time <= '0;
      in_frame       <= 1'b0;
      bits_taken     <= '0;
      shift_word     <= '0;
      packet_ready   <= 1'b0;
    end else if (take) begin
      last_edge_time <= last_edge_time_next;
      in_frame       <= in_frame_next;
      bits_taken     <= bits_taken_next;
      shift_word     <= shift_word_next;
      packet_ready   <= packet_ready_next;
    end
  end

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// testbench for ir_pulse_distance_receiver_top: drives edge and read words and
// checks every result word against a cycle-free decode of the same frame timing
// depends on irpd_pkg and the receiver rtl
`timescale 1ns / 1ps

import irpd_pkg::*;

// decode tracker: follows the receiver state and holds the results still owed
class frame_decode_tracker #(int FRAME_BITS = 24);
  cfg_t             cfg;
  logic [TIME_W-1:0] last_time;
  logic             in_frame;
  logic [BITS_W-1:0] bits_taken;
  logic [WORD_W-1:0] shift_word;
  logic             packet_ready;
  out_t             owed_decodes[$];
  int               errors;
  int               checked;

  function new();
    cfg = '{leader_min: LEADER_MIN_RST, leader_max: LEADER_MAX_RST,
            bit_min: BIT_MIN_RST, bit_max: BIT_MAX_RST,
            one_threshold: ONE_THRESHOLD_RST};
    last_time    = '0;
    in_frame     = 1'b0;
    bits_taken   = '0;
    shift_word   = '0;
    packet_ready = 1'b0;
    errors       = 0;
    checked      = 0;
  endfunction

  function void set_reg(logic [INDEX_W-1:0] idx, logic [CFG_W-1:0] value);
    case (idx)
      REG_LEADER_MIN:    cfg.leader_min    = value;
      REG_LEADER_MAX:    cfg.leader_max    = value;
      REG_BIT_MIN:       cfg.bit_min       = value;
      REG_BIT_MAX:       cfg.bit_max       = value;
      REG_ONE_THRESHOLD: cfg.one_threshold = value;
      default: ;
    endcase
  endfunction

  // work out the result of one accepted word and queue it
  function void take_word(in_t w);
    out_t              r;
    logic [TIME_W-1:0] gap;
    r = '0;
    if (w.op == OP_READ) begin
      if (packet_ready) begin
        r.read_ok    = 1'b1;
        r.packet     = shift_word;
        packet_ready = 1'b0;
      end
    end else begin
      gap       = w.edge_time - last_time;
      last_time = w.edge_time;
      if (!in_frame) begin
        // leader starts a frame, anything else is ignored while idle
        if (gap >= cfg.leader_min && gap <= cfg.leader_max) begin
          in_frame   = 1'b1;
          bits_taken = '0;
          shift_word = '0;
        end
      end else if (gap >= cfg.bit_min && gap <= cfg.bit_max) begin
        // data bit, lsb first; positions past the word are counted only
        if (bits_taken < WORD_W && gap >= cfg.one_threshold)
          shift_word[bits_taken[4:0]] = 1'b1;
        bits_taken = bits_taken + 1'b1;
        if (bits_taken >= FRAME_BITS) begin
          packet_ready = 1'b1;
          in_frame     = 1'b0;
          r.frame_done = 1'b1;
        end
      end else begin
        // out-of-window interval drops the frame
        in_frame   = 1'b0;
        bits_taken = '0;
        shift_word = '0;
      end
    end
    r.receiving = in_frame;
    owed_decodes.push_back(r);
  endfunction

  task report(string what);
    errors++;
    $display("decode mismatch at result %0d: %s", checked, what);
  endtask

  task check_result(out_t got);
    out_t want;
    if (owed_decodes.size() == 0) begin
      report($sformatf("result word %h with nothing owed", got));
    end else begin
      want = owed_decodes.pop_front();
      if (got.read_ok !== want.read_ok)
        report($sformatf("read_ok %b, want %b", got.read_ok, want.read_ok));
      if (got.packet !== want.packet)
        report($sformatf("packet %h, want %h", got.packet, want.packet));
      if (got.receiving !== want.receiving)
        report($sformatf("receiving %b, want %b", got.receiving, want.receiving));
      if (got.frame_done !== want.frame_done)
        report($sformatf("frame_done %b, want %b", got.frame_done, want.frame_done));
    end
    checked++;
  endtask
endclass

module testbench;
  localparam int FRAME_BITS   = 24;
  localparam int HOLD_CYCLES  = 200;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 6;

  logic               clk      = 1'b0;
  logic               rst      = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_t                in_data  = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_t               out_data;
  logic               wr_en    = 1'b0;
  logic [INDEX_W-1:0] wr_index = '0;
  logic [CFG_W-1:0]   wr_data  = '0;

  frame_decode_tracker #(FRAME_BITS) board;

  logic [TIME_W-1:0] stamp = '0;
  int items_sent  = 0;
  int burst_left  = 0;
  bit gaps_on     = 1'b1;
  bit hold_req    = 1'b0;
  bit hold_done   = 1'b0;
  int quiet_cycles = 0;

  ir_pulse_distance_receiver_top #(.PACKET_BITS(FRAME_BITS)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_result(out_data);
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // receiver: random stall stretches, one long hold-off on request
  initial begin
    int mode;
    int len;
    forever begin
      if (hold_req && !hold_done) begin
        @(negedge clk);
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        mode = $urandom_range(2);
        len  = $urandom_range(24, 1);
        repeat (len) begin
          @(negedge clk);
          case (mode)
            0:       out_ready = 1'b1;
            1:       out_ready = 1'($urandom_range(1));
            default: out_ready = ($urandom_range(3) == 0);
          endcase
        end
      end
    end
  end

  function automatic logic [TIME_W-1:0] pick(int unsigned lo, int unsigned hi);
    return $urandom_range(hi, lo);
  endfunction

  // offer one word in bursts with random gaps, return once it is taken
  task automatic send_word(in_t w);
    int gap;
    if (burst_left == 0) begin
      if (gaps_on) begin
        gap = $urandom_range(3) == 0 ? 0 : $urandom_range(6, 1);
        if (gap > 0) begin
          @(negedge clk);
          in_valid = 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
      burst_left = $urandom_range(40, 1);
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = w;
    do @(posedge clk); while (!in_ready);
    board.take_word(w);
    items_sent++;
  endtask

  task automatic send_edge(logic [TIME_W-1:0] step);
    in_t w;
    stamp       = stamp + step;
    w.op        = OP_EDGE;
    w.edge_time = stamp;
    send_word(w);
  endtask

  task automatic send_read(logic [TIME_W-1:0] junk);
    in_t w;
    w.op        = OP_READ;
    w.edge_time = junk;
    send_word(w);
  endtask

  // leader then data bits drawn from the live windows; broken frames abort
  task automatic send_frame(bit broken);
    int cut;
    int bmin, bmax, thr, lo0, hi0, lo1, hi1;
    logic [TIME_W-1:0] step;
    bmin = 32'(board.cfg.bit_min);
    bmax = 32'(board.cfg.bit_max);
    thr  = 32'(board.cfg.one_threshold);
    lo0  = bmin;
    hi0  = (thr - 1 < bmax) ? thr - 1 : bmax;
    lo1  = (thr > bmin) ? thr : bmin;
    hi1  = bmax;
    cut  = broken ? $urandom_range(FRAME_BITS - 1) : FRAME_BITS;
    if (board.cfg.leader_min <= board.cfg.leader_max)
      send_edge(pick(32'(board.cfg.leader_min), 32'(board.cfg.leader_max)));
    else
      send_edge($urandom);
    for (int i = 0; i < FRAME_BITS; i++) begin
      if ($urandom_range(9) == 0)
        send_read($urandom);
      if (i == cut) begin
        if (bmin > 0 && $urandom_range(1))
          step = pick(0, bmin - 1);
        else
          step = bmax + 1 + $urandom_range(100000);
        send_edge(step);
        return;
      end
      if (lo1 <= hi1 && ($urandom_range(1) || lo0 > hi0))
        step = pick(lo1, hi1);
      else if (lo0 <= hi0)
        step = pick(lo0, hi0);
      else
        step = $urandom;
      send_edge(step);
    end
  endtask

  // mostly clean frames, plus broken frames, stray edges and reads
  task automatic random_traffic(int n);
    int goal;
    int kind;
    goal = items_sent + n;
    while (items_sent < goal) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        send_frame(1'b0);
        if ($urandom_range(9) < 6)
          send_read($urandom);
      end else if (kind < 70) begin
        send_frame(1'b1);
      end else if (kind < 85) begin
        send_edge($urandom_range(1) ? $urandom : $urandom_range(20000));
      end else begin
        send_read($urandom);
      end
    end
  endtask

  // let the pipe empty before touching the registers
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (board.owed_decodes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(logic [INDEX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    wr_en    = 1'b1;
    wr_index = idx;
    wr_data  = value;
    board.set_reg(idx, value);
  endtask

  task automatic apply_config(cfg_t c);
    write_reg(REG_LEADER_MIN, c.leader_min);
    write_reg(REG_LEADER_MAX, c.leader_max);
    write_reg(REG_BIT_MIN, c.bit_min);
    write_reg(REG_BIT_MAX, c.bit_max);
    write_reg(REG_ONE_THRESHOLD, c.one_threshold);
    @(negedge clk);
    wr_en = 1'b0;
  endtask

  initial begin
    logic [TIME_W-1:0] step;
    cfg_t c;
    board = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: read with nothing ready, first edge at time zero,
    // all-ones timestamp, leader across the wrap, corner bit intervals
    stamp = '0;
    send_read(32'hFFFF_FFFF);
    send_edge(32'd0);
    send_edge(32'hFFFF_FFFF);
    send_edge(32'd13500);
    for (int i = 0; i < FRAME_BITS; i++) begin
      case (i)
        0:       step = TIME_W'(board.cfg.one_threshold);
        1:       step = TIME_W'(board.cfg.bit_min);
        2:       step = TIME_W'(board.cfg.bit_max);
        3:       step = TIME_W'(board.cfg.one_threshold - 1'b1);
        default: step = pick(32'(board.cfg.bit_min), 32'(board.cfg.bit_max));
      endcase
      send_edge(step);
    end
    // new leader while the packet is still unread, then one bit and a read
    send_edge(TIME_W'(board.cfg.leader_max));
    send_edge(TIME_W'(board.cfg.one_threshold));
    send_read($urandom);

    random_traffic(40);

    // plausible random timing, no sender gaps and one long receiver hold-off
    settle();
    c.leader_min    = CFG_W'($urandom_range(12000, 5000));
    c.leader_max    = c.leader_min + CFG_W'($urandom_range(8000));
    c.bit_min       = CFG_W'($urandom_range(1000, 100));
    c.bit_max       = c.bit_min + CFG_W'($urandom_range(4000, 500));
    c.one_threshold = CFG_W'($urandom_range(c.bit_max, c.bit_min));
    apply_config(c);
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    random_traffic(80);
    while (!hold_done) @(posedge clk);
    hold_req = 1'b0;
    gaps_on  = 1'b1;

    // all registers zero: only repeated timestamps decode
    settle();
    apply_config('{leader_min: 16'h0000, leader_max: 16'h0000, bit_min: 16'h0000,
                   bit_max: 16'h0000, one_threshold: 16'h0000});
    random_traffic(40);

    // all registers at full scale
    settle();
    apply_config('{leader_min: 16'hFFFF, leader_max: 16'hFFFF, bit_min: 16'hFFFF,
                   bit_max: 16'hFFFF, one_threshold: 16'hFFFF});
    random_traffic(40);

    // empty bit window: every leader is followed by an abort
    settle();
    apply_config('{leader_min: 16'h8000, leader_max: 16'hFFFF, bit_min: 16'hFFFF,
                   bit_max: 16'h0000, one_threshold: 16'h5555});
    random_traffic(20);

    // empty leader window: nothing ever starts
    settle();
    apply_config('{leader_min: 16'hFFFF, leader_max: 16'h0000, bit_min: 16'd700,
                   bit_max: 16'd3000, one_threshold: 16'd1600});
    random_traffic(20);

    // fully random registers
    settle();
    c.leader_min    = CFG_W'($urandom);
    c.leader_max    = CFG_W'($urandom);
    c.bit_min       = CFG_W'($urandom);
    c.bit_max       = CFG_W'($urandom);
    c.one_threshold = CFG_W'($urandom);
    apply_config(c);
    random_traffic(40);

    // wide windows with a random threshold
    settle();
    c.leader_min    = CFG_W'($urandom_range(100));
    c.leader_max    = 16'hFFFF;
    c.bit_min       = 16'h0000;
    c.bit_max       = CFG_W'($urandom_range(16'hFFFF, 16'h1000));
    c.one_threshold = CFG_W'($urandom_range(c.bit_max));
    apply_config(c);
    random_traffic(60);

    settle();
    if (board.owed_decodes.size() != 0)
      board.report($sformatf("%0d results never arrived", board.owed_decodes.size()));
    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// ----- ir_pulse_distance_receiver_top.f -----
hw/rtl/irpd_pkg.sv
hw/rtl/irpd_core.sv
hw/rtl/ir_pulse_distance_receiver_top.sv
test/testbench.sv
